@@ rtl/core/bai_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_pkg
// Shared constants and pipeline stage types of the binary32 integer adder.
// ----------------------------------------------------------------------------
package bai_pkg;

    localparam logic [7:0]  C_EXP_MAX  = 8'hff;
    localparam logic [31:0] C_INF_BITS = 32'h7f80_0000;
    localparam logic [31:0] C_ZERO     = 32'h0000_0000;
    localparam int unsigned C_MAN_W    = 27;
    localparam logic [4:0]  C_SHIFT_MAX = 5'd31;

    // After unpacking and exponent compare.
    typedef struct packed {
        logic                 valid;
        logic                 special;
        logic [31:0]          spec_res;
        logic                 sa;
        logic                 sb;
        logic [C_MAN_W-1:0]   fa;
        logic [C_MAN_W-1:0]   fb;
        logic                 shift_a;
        logic [4:0]           shamt;
        logic [7:0]           expo;
    } t_unp;

    // After alignment.
    typedef struct packed {
        logic                 valid;
        logic                 special;
        logic [31:0]          spec_res;
        logic                 sa;
        logic                 sb;
        logic [C_MAN_W-1:0]   fa;
        logic [C_MAN_W-1:0]   fb;
        logic [7:0]           expo;
    } t_aln;

    // After add/subtract, and after normalization.
    typedef struct packed {
        logic                 valid;
        logic                 special;
        logic [31:0]          spec_res;
        logic                 sign;
        logic [C_MAN_W-1:0]   man;
        logic [7:0]           expo;
    } t_mag;

endpackage

@@ rtl/core/bai_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_in_if / bai_out_if
// Valid/ready channels for the operand pair and the sum.
// ----------------------------------------------------------------------------
interface bai_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] a_bits;
    logic [31:0] b_bits;

    modport source (output valid, output a_bits, output b_bits, input ready);
    modport sink   (input valid, input a_bits, input b_bits, output ready);
endinterface

interface bai_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum_bits;

    modport source (output valid, output sum_bits, input ready);
    modport sink   (input valid, input sum_bits, output ready);
endinterface

@@ rtl/core/bai_align.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_align
// Stages 1 and 2: unpack, special operands, exponent compare, alignment.
// ----------------------------------------------------------------------------
module bai_align
    import bai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_a_bits,
    input  logic [31:0] i_b_bits,
    output t_aln        o_aln
);

    t_unp r_unp, n_unp;
    t_aln r_aln, n_aln;

    always_comb begin
        logic [7:0] ea, eb;
        logic [7:0] diff;
        ea = (i_a_bits[30:23] == 8'd0) ? 8'd1 : i_a_bits[30:23];
        eb = (i_b_bits[30:23] == 8'd0) ? 8'd1 : i_b_bits[30:23];

        n_unp.valid    = i_valid;
        n_unp.sa       = i_a_bits[31];
        n_unp.sb       = i_b_bits[31];
        n_unp.fa       = {(i_a_bits[30:23] != 8'd0), i_a_bits[22:0], 3'b000};
        n_unp.fb       = {(i_b_bits[30:23] != 8'd0), i_b_bits[22:0], 3'b000};
        n_unp.shift_a  = (ea < eb);
        diff           = n_unp.shift_a ? (eb - ea) : (ea - eb);
        n_unp.shamt    = (diff > 8'd31) ? C_SHIFT_MAX : diff[4:0];
        n_unp.expo     = n_unp.shift_a ? eb : ea;

        // Zero operands first, then NaN or infinity, a ahead of b.
        n_unp.special  = 1'b1;
        if (i_a_bits[30:0] == 31'd0) begin
            n_unp.spec_res = i_b_bits;
        end else if (i_b_bits[30:0] == 31'd0) begin
            n_unp.spec_res = i_a_bits;
        end else if (i_a_bits[30:23] == C_EXP_MAX) begin
            n_unp.spec_res = i_a_bits;
        end else if (i_b_bits[30:23] == C_EXP_MAX) begin
            n_unp.spec_res = i_b_bits;
        end else begin
            n_unp.special  = 1'b0;
            n_unp.spec_res = C_ZERO;
        end
    end

    always_comb begin
        n_aln.valid    = r_unp.valid;
        n_aln.special  = r_unp.special;
        n_aln.spec_res = r_unp.spec_res;
        n_aln.sa       = r_unp.sa;
        n_aln.sb       = r_unp.sb;
        n_aln.expo     = r_unp.expo;
        n_aln.fa       = r_unp.shift_a ? (r_unp.fa >> r_unp.shamt) : r_unp.fa;
        n_aln.fb       = r_unp.shift_a ? r_unp.fb : (r_unp.fb >> r_unp.shamt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unp.valid <= 1'b0;
            r_aln.valid <= 1'b0;
        end else if (i_en) begin
            r_unp <= n_unp;
            r_aln <= n_aln;
        end
    end

    assign o_aln = r_aln;

endmodule

@@ rtl/core/bai_addnorm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_addnorm
// Stages 3 and 4: signed magnitude add or subtract, then normalization.
// ----------------------------------------------------------------------------
module bai_addnorm
    import bai_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_aln i_aln,
    output t_mag o_nrm
);

    t_mag r_sum, n_sum;
    t_mag r_nrm, n_nrm;

    always_comb begin
        logic [C_MAN_W:0] total;
        logic             ge;
        total = {1'b0, i_aln.fa} + {1'b0, i_aln.fb};
        ge    = (i_aln.fa >= i_aln.fb);

        n_sum.valid    = i_aln.valid;
        n_sum.expo     = i_aln.expo;
        if (i_aln.sa == i_aln.sb) begin
            n_sum.sign = i_aln.sa;
            if (total[C_MAN_W]) begin
                // Carry out: the lowest bit is dropped.
                n_sum.man  = total[C_MAN_W:1];
                n_sum.expo = i_aln.expo + 8'd1;
            end else begin
                n_sum.man  = total[C_MAN_W-1:0];
            end
        end else begin
            n_sum.sign = ge ? i_aln.sa : i_aln.sb;
            n_sum.man  = ge ? (i_aln.fa - i_aln.fb) : (i_aln.fb - i_aln.fa);
        end

        // Exact cancellation gives plus zero.
        if (i_aln.special) begin
            n_sum.special  = 1'b1;
            n_sum.spec_res = i_aln.spec_res;
        end else if (n_sum.man == '0) begin
            n_sum.special  = 1'b1;
            n_sum.spec_res = C_ZERO;
        end else begin
            n_sum.special  = 1'b0;
            n_sum.spec_res = C_ZERO;
        end
    end

    // The shift is min(leading zeros, exponent - 1), built greedily from
    // power-of-two steps so the exponent never drops below one.
    always_comb begin
        logic [C_MAN_W-1:0] m;
        logic [7:0]         e;
        m = r_sum.man;
        e = r_sum.expo;
        if (m[26:11] == 16'd0 && e > 8'd16) begin
            m = m << 16;
            e = e - 8'd16;
        end
        if (m[26:19] == 8'd0 && e > 8'd8) begin
            m = m << 8;
            e = e - 8'd8;
        end
        if (m[26:23] == 4'd0 && e > 8'd4) begin
            m = m << 4;
            e = e - 8'd4;
        end
        if (m[26:25] == 2'd0 && e > 8'd2) begin
            m = m << 2;
            e = e - 8'd2;
        end
        if (!m[26] && e > 8'd1) begin
            m = m << 1;
            e = e - 8'd1;
        end
        n_nrm          = r_sum;
        n_nrm.man      = m;
        n_nrm.expo     = e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum.valid <= 1'b0;
            r_nrm.valid <= 1'b0;
        end else if (i_en) begin
            r_sum <= n_sum;
            r_nrm <= n_nrm;
        end
    end

    assign o_nrm = r_nrm;

endmodule

@@ rtl/core/bai_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_round
// Stage 5: round to nearest even, overflow to infinity, pack.
// ----------------------------------------------------------------------------
module bai_round
    import bai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_mag        i_nrm,
    output logic        o_valid,
    output logic [31:0] o_sum_bits
);

    logic        r_valid;
    logic [31:0] r_sum_bits, n_sum_bits;

    always_comb begin
        logic             up;
        logic [C_MAN_W:0] mr;
        logic [C_MAN_W-1:0] m;
        logic [8:0]       e;
        up = (i_nrm.man[2:0] > 3'd4) || (i_nrm.man[2:0] == 3'd4 && i_nrm.man[3]);
        mr = {1'b0, i_nrm.man} + (up ? 28'd8 : 28'd0);
        e  = {1'b0, i_nrm.expo};
        if (mr[C_MAN_W]) begin
            m = mr[C_MAN_W:1];
            e = e + 9'd1;
        end else begin
            m = mr[C_MAN_W-1:0];
        end

        if (i_nrm.special) begin
            n_sum_bits = i_nrm.spec_res;
        end else if (e >= {1'b0, C_EXP_MAX}) begin
            n_sum_bits = {i_nrm.sign, C_INF_BITS[30:0]};
        end else if (e == 9'd1 && !m[26]) begin
            // Subnormal result: zero exponent field.
            n_sum_bits = {i_nrm.sign, 8'd0, m[25:3]};
        end else begin
            n_sum_bits = {i_nrm.sign, e[7:0], m[25:3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid    <= i_nrm.valid;
            r_sum_bits <= n_sum_bits;
        end
    end

    assign o_valid    = r_valid;
    assign o_sum_bits = r_sum_bits;

endmodule

@@ rtl/core/binary32_adder_integer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_adder_integer
// Adds two binary32 bit patterns with an integer datapath.
// ----------------------------------------------------------------------------
// Five-stage pipeline: unpack and exponent compare, alignment shift,
// add/subtract, normalize, round and pack. One operand pair is accepted per
// cycle while i_in.ready is high; its sum is offered from the fifth register,
// and the whole pipeline holds as one while the output item waits, so
// i_in.ready follows o_out.ready or an empty output register.
module binary32_adder_integer
    import bai_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    bai_in_if.sink          i_in,
    bai_out_if.source       o_out
);

    logic en;
    t_aln aln;
    t_mag nrm;
    logic out_valid;

    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = out_valid;

    bai_align u_align (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_a_bits (i_in.a_bits),
        .i_b_bits (i_in.b_bits),
        .o_aln    (aln)
    );

    bai_addnorm u_addnorm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_aln   (aln),
        .o_nrm   (nrm)
    );

    bai_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_nrm      (nrm),
        .o_valid    (out_valid),
        .o_sum_bits (o_out.sum_bits)
    );

endmodule

@@ rtl/core/bai_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_checker
// Port-level assertions for the binary32 integer adder.
// ----------------------------------------------------------------------------
module bai_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_sum_bits
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sum_bits)))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is taken");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without a waiting output item");

endmodule

bind binary32_adder_integer bai_checker u_bai_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_sum_bits (o_out.sum_bits)
);
